@@ src/vfc_pkg.sv @@
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types, constants and face tables of the voxel face culler.
// ----------------------------------------------------------------------------
package vfc_pkg;

    localparam int CHUNK_EDGE_DEF = 16;
    localparam int TYPE_BITS_DEF  = 6;
    localparam int COORD_W        = 4;
    localparam int WORLD_W        = 20;
    localparam int POS_W          = 16;
    localparam int MASK_W         = 64;
    localparam int FTYPE_W        = 6;
    localparam int CFG_DATA_W     = 64;

    typedef enum logic [1:0] {
        CFG_OPAQUE_MASK = 2'd0,
        CFG_AIR_TYPE    = 2'd1,
        CFG_CHUNK_POS_X = 2'd2,
        CFG_CHUNK_POS_Z = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        FACE_PZ = 3'd0,
        FACE_NZ = 3'd1,
        FACE_NX = 3'd2,
        FACE_PX = 3'd3,
        FACE_PY = 3'd4,
        FACE_NY = 3'd5
    } face_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CTR_RD,
        ST_CTR_CHK,
        ST_NEIGH,
        ST_FACE_SEL,
        ST_AO,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic [MASK_W-1:0]       opaque_mask;
        logic [FTYPE_W-1:0]      air_type;
        logic signed [POS_W-1:0] chunk_pos_x;
        logic signed [POS_W-1:0] chunk_pos_z;
    } cfg_t;

    typedef struct packed {
        logic signed [WORLD_W-1:0] world_x;
        logic [COORD_W-1:0]        world_y;
        logic signed [WORLD_W-1:0] world_z;
        logic [2:0]                face;
        logic [FTYPE_W-1:0]        face_type;
        logic [1:0]                ao_v0;
        logic [1:0]                ao_v1;
        logic [1:0]                ao_v2;
        logic [1:0]                ao_v3;
        logic                      last;
    } rec_t;

    typedef struct packed {
        logic signed [1:0] dx;
        logic signed [1:0] dy;
        logic signed [1:0] dz;
    } offs_t;

    function automatic offs_t face_norm(face_t f);
        offs_t o;
        o = '{dx: 2'sd0, dy: 2'sd0, dz: 2'sd0};
        unique case (f)
            FACE_PZ: o.dz = 2'sd1;
            FACE_NZ: o.dz = -2'sd1;
            FACE_NX: o.dx = -2'sd1;
            FACE_PX: o.dx = 2'sd1;
            FACE_PY: o.dy = 2'sd1;
            FACE_NY: o.dy = -2'sd1;
            default: o = '{dx: 2'sd0, dy: 2'sd0, dz: 2'sd0};
        endcase
        return o;
    endfunction

    // cell k of the 3x3 layer beyond the face, center left out, row-major in (u, v)
    function automatic offs_t ao_cell(face_t f, logic [2:0] k);
        offs_t o;
        logic signed [1:0] u;
        logic signed [1:0] v;
        o = face_norm(f);
        unique case (k)
            3'd0: begin u = -2'sd1; v = -2'sd1; end
            3'd1: begin u = -2'sd1; v = 2'sd0;  end
            3'd2: begin u = -2'sd1; v = 2'sd1;  end
            3'd3: begin u = 2'sd0;  v = -2'sd1; end
            3'd4: begin u = 2'sd0;  v = 2'sd1;  end
            3'd5: begin u = 2'sd1;  v = -2'sd1; end
            3'd6: begin u = 2'sd1;  v = 2'sd0;  end
            default: begin u = 2'sd1; v = 2'sd1; end
        endcase
        unique case (f)
            FACE_PZ, FACE_NZ: begin o.dx = u; o.dy = v; end
            FACE_NX, FACE_PX: begin o.dy = u; o.dz = v; end
            default:          begin o.dx = u; o.dz = v; end
        endcase
        return o;
    endfunction

    // tangent directions {d0, d1} of each vertex, vertex 3 in the top bits
    function automatic logic [7:0] vert_dirs(face_t f);
        logic [7:0] r;
        unique case (f)
            FACE_PZ: r = {2'b01, 2'b11, 2'b10, 2'b00};
            FACE_NZ: r = {2'b11, 2'b01, 2'b00, 2'b10};
            FACE_NX: r = {2'b10, 2'b11, 2'b01, 2'b00};
            FACE_PX: r = {2'b11, 2'b10, 2'b00, 2'b01};
            FACE_PY: r = {2'b00, 2'b10, 2'b11, 2'b01};
            default: r = {2'b01, 2'b11, 2'b10, 2'b00};
        endcase
        return r;
    endfunction

    function automatic logic [1:0] ao_code(logic [7:0] occ, logic [1:0] dir);
        logic s0;
        logic s1;
        logic c;
        s0 = dir[1] ? occ[6] : occ[1];
        s1 = dir[0] ? occ[4] : occ[3];
        unique case (dir)
            2'b00: c = occ[0];
            2'b01: c = occ[2];
            2'b10: c = occ[5];
            default: c = occ[7];
        endcase
        if (s0 && s1)
            return 2'd3;
        return 2'(s0) + 2'(s1) + 2'(c);
    endfunction

endpackage

@@ src/vfc_if.sv @@
// ----------------------------------------------------------------------------
// vfc_if
// Valid/ready channels of the voxel face culler: block items in, face records out.
// ----------------------------------------------------------------------------
interface vfc_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [3:0] block_x;
    logic [3:0] block_y;
    logic [3:0] block_z;
    logic [5:0] block_type;

    modport source (output valid, op, block_x, block_y, block_z, block_type, input ready);
    modport sink   (input valid, op, block_x, block_y, block_z, block_type, output ready);
endinterface

interface vfc_out_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] world_x;
    logic [3:0]         world_y;
    logic signed [19:0] world_z;
    logic [2:0]         face;
    logic [5:0]         face_type;
    logic [1:0]         ao_v0;
    logic [1:0]         ao_v1;
    logic [1:0]         ao_v2;
    logic [1:0]         ao_v3;
    logic               last;

    modport source (output valid, world_x, world_y, world_z, face, face_type,
                    ao_v0, ao_v1, ao_v2, ao_v3, last, input ready);
    modport sink   (input valid, world_x, world_y, world_z, face, face_type,
                    ao_v0, ao_v1, ao_v2, ao_v3, last, output ready);
endinterface

@@ src/vfc_store.sv @@
// ----------------------------------------------------------------------------
// vfc_store
// Block type memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vfc_store #(
    parameter int ADDR_W    = 12,
    parameter int TYPE_BITS = 6
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  logic [TYPE_BITS-1:0] wdata,
    input  logic [ADDR_W-1:0]    raddr,
    output logic [TYPE_BITS-1:0] rdata
);

    logic [TYPE_BITS-1:0] mem [2**ADDR_W];
    logic [TYPE_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/vfc_seq.sv @@
// ----------------------------------------------------------------------------
// vfc_seq
// Mesh sequencer: walks center, face neighbors and occlusion cells through
// the one read port and a shared opacity test, then builds face records.
// ----------------------------------------------------------------------------
module vfc_seq
    import vfc_pkg::*;
#(
    parameter int CHUNK_EDGE = CHUNK_EDGE_DEF,
    parameter int TYPE_BITS  = TYPE_BITS_DEF,
    parameter int CB         = $clog2(CHUNK_EDGE)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [CB-1:0]        start_x,
    input  logic [CB-1:0]        start_y,
    input  logic [CB-1:0]        start_z,
    input  cfg_t                 cfg,
    output logic [3*CB-1:0]      raddr,
    input  logic [TYPE_BITS-1:0] rdata,
    output logic                 idle,
    output logic                 rec_valid,
    output rec_t                 rec,
    input  logic                 rec_ok
);

    localparam int CW = CB + 2;
    localparam logic signed [CW-1:0] EDGE_C = CW'(CHUNK_EDGE);
    localparam logic signed [WORLD_W-1:0] EDGE_W = WORLD_W'(CHUNK_EDGE);

    seq_state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [5:0] exposed_reg, exposed_next;
    logic [7:0] occ_reg, occ_next;
    face_t face_reg, face_next;
    logic [TYPE_BITS-1:0] ctype_reg, ctype_next;
    logic [CB-1:0] x_reg, y_reg, z_reg;
    logic inb_reg;

    offs_t off;
    logic signed [CW-1:0] cx, cy, cz;
    logic inb;
    logic opq;
    logic [7:0] t8;
    logic [7:0] dirs;
    logic [2:0] nf;
    logic nf_found;

    function automatic logic in_rng(logic signed [CW-1:0] c);
        return (c[CW-1] == 1'b0) && (c < EDGE_C);
    endfunction

    // cell being addressed this cycle
    always_comb
    begin
        off = '{dx: 2'sd0, dy: 2'sd0, dz: 2'sd0};
        unique case (state_reg)
            ST_NEIGH: off = face_norm(face_t'(cnt_reg[2:0]));
            ST_AO:    off = ao_cell(face_reg, cnt_reg[2:0]);
            default:  off = '{dx: 2'sd0, dy: 2'sd0, dz: 2'sd0};
        endcase
    end

    assign cx = $signed({2'b00, x_reg}) + CW'(off.dx);
    assign cy = $signed({2'b00, y_reg}) + CW'(off.dy);
    assign cz = $signed({2'b00, z_reg}) + CW'(off.dz);
    assign inb = in_rng(cx) && in_rng(cy) && in_rng(cz);
    assign raddr = {cx[CB-1:0], cy[CB-1:0], cz[CB-1:0]};

    // shared opacity test on the registered read data
    assign t8 = 8'(rdata);
    assign opq = inb_reg && (t8 < 8'd64) && cfg.opaque_mask[t8[5:0]];

    always_comb
    begin
        nf = 3'd0;
        nf_found = 1'b0;
        for (int i = 5; i >= 0; i--)
        begin
            if (exposed_reg[i])
            begin
                nf = 3'(i);
                nf_found = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        exposed_reg <= exposed_next;
        occ_reg     <= occ_next;
        face_reg    <= face_next;
        ctype_reg   <= ctype_next;
        inb_reg     <= inb;
        if (start)
        begin
            x_reg <= start_x;
            y_reg <= start_y;
            z_reg <= start_z;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        exposed_next = exposed_reg;
        occ_next     = occ_reg;
        face_next    = face_reg;
        ctype_next   = ctype_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CTR_RD;
                end
            end
            ST_CTR_RD:
            begin
                state_next = ST_CTR_CHK;
            end
            ST_CTR_CHK:
            begin
                ctype_next = rdata;
                cnt_next   = 4'd0;
                if (8'(rdata) == 8'(cfg.air_type))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_NEIGH;
                end
            end
            ST_NEIGH:
            begin
                if (cnt_reg != 4'd0)
                begin
                    exposed_next[3'(cnt_reg - 4'd1)] = !opq;
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd6)
                begin
                    state_next = ST_FACE_SEL;
                end
            end
            ST_FACE_SEL:
            begin
                cnt_next = 4'd0;
                if (nf_found)
                begin
                    face_next        = face_t'(nf);
                    exposed_next[nf] = 1'b0;
                    state_next       = ST_AO;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_AO:
            begin
                if (cnt_reg != 4'd0)
                begin
                    occ_next[3'(cnt_reg - 4'd1)] = opq;
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd8)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (rec_ok)
                begin
                    state_next = ST_FACE_SEL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign dirs = vert_dirs(face_reg);

    always_comb
    begin
        rec.world_x   = EDGE_W * WORLD_W'(cfg.chunk_pos_x) + WORLD_W'(x_reg);
        rec.world_y   = COORD_W'(y_reg);
        rec.world_z   = EDGE_W * WORLD_W'(cfg.chunk_pos_z) + WORLD_W'(z_reg);
        rec.face      = face_reg;
        rec.face_type = FTYPE_W'(ctype_reg);
        rec.ao_v0     = ao_code(occ_reg, dirs[1:0]);
        rec.ao_v1     = ao_code(occ_reg, dirs[3:2]);
        rec.ao_v2     = ao_code(occ_reg, dirs[5:4]);
        rec.ao_v3     = ao_code(occ_reg, dirs[7:6]);
        rec.last      = (exposed_reg == 6'd0);
    end

    assign rec_valid = (state_reg == ST_EMIT);
    assign idle      = (state_reg == ST_IDLE);

endmodule

@@ src/voxel_face_cull_ao_top.sv @@
// load transaction: written into block memory in the accept cycle
// mesh transaction: reads the center (ends there for air) and six neighbors and picks a face, then
// per exposed face reads eight occlusion cells, emits the record and selects the next face
// throughput: loads every cycle while the sequencer is idle; a new item waits until a mesh, stalls included, is done
// reset: rst_n clears control and config registers; block memory is not cleared
// ----------------------------------------------------------------------------
// voxel_face_cull_ao_top
// Voxel chunk face culler with per-vertex ambient occlusion levels.
// ----------------------------------------------------------------------------
module voxel_face_cull_ao_top
    import vfc_pkg::*;
#(
    parameter int CHUNK_EDGE = CHUNK_EDGE_DEF,
    parameter int TYPE_BITS  = TYPE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    vfc_in_if.sink                in_ch,
    vfc_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CB = $clog2(CHUNK_EDGE);

    cfg_t cfg_reg;
    rec_t out_reg;
    logic out_valid_reg;

    logic in_ok;
    logic acc;
    logic [CB-1:0] bx, by, bz;
    logic [3*CB-1:0] raddr;
    logic [TYPE_BITS-1:0] rdata;
    logic seq_idle;
    logic rec_valid;
    rec_t rec;
    logic rec_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_OPAQUE_MASK: cfg_reg.opaque_mask <= cfg_wdata;
                CFG_AIR_TYPE:    cfg_reg.air_type    <= cfg_wdata[FTYPE_W-1:0];
                CFG_CHUNK_POS_X: cfg_reg.chunk_pos_x <= cfg_wdata[POS_W-1:0];
                CFG_CHUNK_POS_Z: cfg_reg.chunk_pos_z <= cfg_wdata[POS_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign in_ok = (32'(in_ch.block_x) < CHUNK_EDGE) && (32'(in_ch.block_y) < CHUNK_EDGE)
                && (32'(in_ch.block_z) < CHUNK_EDGE);
    assign in_ch.ready = seq_idle;
    assign acc = in_ch.valid && in_ch.ready;
    assign bx = CB'(in_ch.block_x);
    assign by = CB'(in_ch.block_y);
    assign bz = CB'(in_ch.block_z);

    vfc_store #(
        .ADDR_W    (3 * CB),
        .TYPE_BITS (TYPE_BITS)
    ) u_store (
        .clk   (clk),
        .we    (acc && !in_ch.op && in_ok),
        .waddr ({bx, by, bz}),
        .wdata (TYPE_BITS'(in_ch.block_type)),
        .raddr (raddr),
        .rdata (rdata)
    );

    vfc_seq #(
        .CHUNK_EDGE (CHUNK_EDGE),
        .TYPE_BITS  (TYPE_BITS),
        .CB         (CB)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (acc && in_ch.op && in_ok),
        .start_x   (bx),
        .start_y   (by),
        .start_z   (bz),
        .cfg       (cfg_reg),
        .raddr     (raddr),
        .rdata     (rdata),
        .idle      (seq_idle),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_ok    (rec_ok)
    );

    // output register takes a record when it is empty or is being drained in the same cycle
    assign rec_ok = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rec_valid && rec_ok)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_valid && rec_ok)
        begin
            out_reg <= rec;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.world_x   = out_reg.world_x;
    assign out_ch.world_y   = out_reg.world_y;
    assign out_ch.world_z   = out_reg.world_z;
    assign out_ch.face      = out_reg.face;
    assign out_ch.face_type = out_reg.face_type;
    assign out_ch.ao_v0     = out_reg.ao_v0;
    assign out_ch.ao_v1     = out_reg.ao_v1;
    assign out_ch.ao_v2     = out_reg.ao_v2;
    assign out_ch.ao_v3     = out_reg.ao_v3;
    assign out_ch.last      = out_reg.last;

endmodule

@@ src/vfc_checker.sv @@
// ----------------------------------------------------------------------------
// vfc_checker
// Port-level checks of the voxel face culler, bound to the top level.
// ----------------------------------------------------------------------------
module vfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_op,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  out_face,
    input logic [19:0] out_world_x
);

    // a stalled record stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output record dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_face) && $stable(out_world_x))
        else $error("output record changed while stalled");

    // a load finishes in its accept cycle
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_op |=> in_ready)
        else $error("busy after a load transaction");

    // only a mesh transaction makes the block busy
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid && in_op))
        else $error("busy without a mesh transaction");

endmodule

bind voxel_face_cull_ao_top vfc_checker u_vfc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_op       (in_ch.op),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_face    (out_ch.face),
    .out_world_x (out_ch.world_x)
);

@@ test/tb_vfc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vfc_if
// Testbench-side package of the bench files, kept apart from the RTL sources.
// ----------------------------------------------------------------------------
// The block's own interfaces (vfc_in_if, vfc_out_if) come from the RTL sources.
// This file only holds a small record type used by the scoreboard.
package tb_vfc_pkg;
    import vfc_pkg::*;

    typedef struct {
        logic signed [19:0] world_x;
        logic [3:0]         world_y;
        logic signed [19:0] world_z;
        logic [2:0]         face;
        logic [5:0]         face_type;
        logic [1:0]         ao [4];
        logic               last;
    } face_rec_t;
endpackage

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the voxel face culler: chunk loads and mesh requests go in, and every
// face record coming out is compared with a record predicted from a private
// copy of the chunk and the registers.
// ----------------------------------------------------------------------------
module tb_top;
    import vfc_pkg::*;
    import tb_vfc_pkg::*;

    localparam int EDGE = 16;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    vfc_in_if  in_ch ();
    vfc_out_if out_ch ();

    voxel_face_cull_ao_top uut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    class face_scoreboard;
        logic [5:0]  chunk [EDGE*EDGE*EDGE];
        bit          loaded [EDGE*EDGE*EDGE];
        logic [63:0] opaque_mask;
        logic [5:0]  air_type;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_z;
        face_rec_t   pending [$];
        int          errors;
        int          checked;

        function new();
            errors = 0;
            checked = 0;
            opaque_mask = '0;
            air_type = '0;
            pos_x = '0;
            pos_z = '0;
            foreach (loaded[i]) loaded[i] = 0;
        endfunction

        function bit solid(int x, int y, int z);
            if (x < 0 || y < 0 || z < 0 || x >= EDGE || y >= EDGE || z >= EDGE)
                return 0;
            return opaque_mask[chunk[(x*EDGE + y)*EDGE + z]];
        endfunction

        function void set_reg(cfg_idx_t idx, logic [63:0] v);
            case (idx)
                CFG_OPAQUE_MASK: opaque_mask = v;
                CFG_AIR_TYPE:    air_type = v[5:0];
                CFG_CHUNK_POS_X: pos_x = v[15:0];
                default:         pos_z = v[15:0];
            endcase
        endfunction

        // tangent offset of a vertex: 1 goes positive, 0 negative
        function int vtx_bit(int f, int v, int axis);
            int tbl [6][4][3] = '{
                '{'{0,0,1}, '{1,0,1}, '{1,1,1}, '{0,1,1}},
                '{'{1,0,0}, '{0,0,0}, '{0,1,0}, '{1,1,0}},
                '{'{0,0,0}, '{0,0,1}, '{0,1,1}, '{0,1,0}},
                '{'{1,0,1}, '{1,0,0}, '{1,1,0}, '{1,1,1}},
                '{'{0,1,1}, '{1,1,1}, '{1,1,0}, '{0,1,0}},
                '{'{0,0,0}, '{1,0,0}, '{1,0,1}, '{0,0,1}}};
            return tbl[f][v][axis];
        endfunction

        function void note_item(logic op, int x, int y, int z, logic [5:0] t);
            int nrm [6][3] = '{'{0,0,1}, '{0,0,-1}, '{-1,0,0}, '{1,0,0},
                               '{0,1,0}, '{0,-1,0}};
            int base [3];
            int sd [2][3];
            int cr [3];
            int n;
            int d;
            bit s0;
            bit s1;
            bit c;
            logic [5:0] ct;
            face_rec_t r;
            int first;
            if (op == 1'b0)
            begin
                chunk[(x*EDGE + y)*EDGE + z] = t;
                loaded[(x*EDGE + y)*EDGE + z] = 1;
                return;
            end
            ct = chunk[(x*EDGE + y)*EDGE + z];
            if (ct == air_type)
                return;
            first = pending.size();
            for (int f = 0; f < 6; f++)
            begin
                if (solid(x + nrm[f][0], y + nrm[f][1], z + nrm[f][2]))
                    continue;
                r.world_x = 20'(int'(pos_x) * EDGE + x);
                r.world_y = y[3:0];
                r.world_z = 20'(int'(pos_z) * EDGE + z);
                r.face = f[2:0];
                r.face_type = ct;
                r.last = 0;
                base[0] = x + nrm[f][0];
                base[1] = y + nrm[f][1];
                base[2] = z + nrm[f][2];
                for (int v = 0; v < 4; v++)
                begin
                    cr = base;
                    n = 0;
                    for (int a = 0; a < 3; a++)
                    begin
                        if (nrm[f][a] != 0)
                            continue;
                        d = vtx_bit(f, v, a) ? 1 : -1;
                        sd[n] = base;
                        sd[n][a] += d;
                        cr[a] += d;
                        n++;
                    end
                    s0 = solid(sd[0][0], sd[0][1], sd[0][2]);
                    s1 = solid(sd[1][0], sd[1][1], sd[1][2]);
                    c = solid(cr[0], cr[1], cr[2]);
                    r.ao[v] = (s0 && s1) ? 2'd3 : 2'(s0) + 2'(s1) + 2'(c);
                end
                pending.push_back(r);
            end
            if (pending.size() > first)
                pending[pending.size()-1].last = 1;
        endfunction

        function void check_rec(face_rec_t got);
            face_rec_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected face record face=%0d at x=%0d", $time,
                    got.face, got.world_x);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.world_x !== e.world_x || got.world_y !== e.world_y ||
                got.world_z !== e.world_z || got.face !== e.face ||
                got.face_type !== e.face_type || got.last !== e.last ||
                got.ao[0] !== e.ao[0] || got.ao[1] !== e.ao[1] ||
                got.ao[2] !== e.ao[2] || got.ao[3] !== e.ao[3])
            begin
                $display("%0t: mismatch expected x=%0d y=%0d z=%0d f=%0d t=%0d ao=%0d%0d%0d%0d l=%0d",
                    $time, e.world_x, e.world_y, e.world_z, e.face, e.face_type,
                    e.ao[0], e.ao[1], e.ao[2], e.ao[3], e.last);
                $display("%0t: mismatch actual   x=%0d y=%0d z=%0d f=%0d t=%0d ao=%0d%0d%0d%0d l=%0d",
                    $time, got.world_x, got.world_y, got.world_z, got.face, got.face_type,
                    got.ao[0], got.ao[1], got.ao[2], got.ao[3], got.last);
                errors++;
            end
        endfunction
    endclass

    face_scoreboard faces;
    int gap_left;
    int hold_off;
    int mesh_sent;
    bit stim_done;

    // coordinate within three cells of a chunk side: 0..2 low, 3..5 high
    function automatic int rim(int i);
        return (i < 3) ? i : i + 10;
    endfunction

    // coordinate within two cells of a chunk side: 0..1 low, 2..3 high
    function automatic int near_side(int i);
        return (i < 2) ? i : i + 12;
    endfunction

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // receiver: own stall pattern, plus the long hold-off when asked
    initial
    begin
        int mode;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                hold_off--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                mode = ($time / 4000) % 3;
                if (mode == 0)
                    out_ch.ready <= 1'b1;
                else if (mode == 1)
                    out_ch.ready <= ($urandom_range(0, 3) != 0);
                else
                    out_ch.ready <= ($urandom_range(0, 2) == 0);
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        face_rec_t r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            r.world_x = out_ch.world_x;
            r.world_y = out_ch.world_y;
            r.world_z = out_ch.world_z;
            r.face = out_ch.face;
            r.face_type = out_ch.face_type;
            r.ao[0] = out_ch.ao_v0;
            r.ao[1] = out_ch.ao_v1;
            r.ao[2] = out_ch.ao_v2;
            r.ao[3] = out_ch.ao_v3;
            r.last = out_ch.last;
            faces.check_rec(r);
        end
    end

    task automatic send_item(logic op, int x, int y, int z, logic [5:0] t);
        // bursty sender: random gap between bursts
        if (gap_left == 0 && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.block_x <= x[3:0];
        in_ch.block_y <= y[3:0];
        in_ch.block_z <= z[3:0];
        in_ch.block_type <= t;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        faces.note_item(op, x, y, z, t);
        if (op)
            mesh_sent++;
    endtask

    task automatic go_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (faces.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [63:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        faces.set_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic fill_chunk(int pct_solid, int ntypes);
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 6; j++)
                for (int k = 0; k < 6; k++)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.op <= 1'b0;
                    in_ch.block_x <= 4'(rim(i));
                    in_ch.block_y <= 4'(rim(j));
                    in_ch.block_z <= 4'(rim(k));
                    in_ch.block_type <= ($urandom_range(0, 99) < pct_solid) ?
                        6'($urandom_range(1, ntypes)) : 6'd0;
                    @(posedge clk);
                    while (!in_ch.ready)
                        @(posedge clk);
                    faces.note_item(1'b0, rim(i), rim(j), rim(k), in_ch.block_type);
                end
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic mesh_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(1'b0, rim($urandom_range(0, 5)), rim($urandom_range(0, 5)),
                    rim($urandom_range(0, 5)), 6'($urandom_range(0, 63)));
            else if ($urandom_range(0, 3) == 0)
                send_item(1'b1, $urandom_range(0, 1) * 15, near_side($urandom_range(0, 3)),
                    $urandom_range(0, 1) * 15, 6'($urandom));
            else
                send_item(1'b1, near_side($urandom_range(0, 3)),
                    near_side($urandom_range(0, 3)), near_side($urandom_range(0, 3)),
                    6'($urandom));
        end
    endtask

    initial
    begin
        faces = new();
        gap_left = 0;
        hold_off = 0;
        mesh_sent = 0;
        stim_done = 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_OPAQUE_MASK;
        cfg_wdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.op <= 1'b0;
        in_ch.block_x <= '0;
        in_ch.block_y <= '0;
        in_ch.block_z <= '0;
        in_ch.block_type <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cells near the chunk sides get loaded, meshes stay within two cells of a side
        // so no mesh reads an unloaded entry
        write_reg(CFG_OPAQUE_MASK, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(CFG_AIR_TYPE, 6'd0);
        write_reg(CFG_CHUNK_POS_X, 64'h7FFF);
        write_reg(CFG_CHUNK_POS_Z, 64'h8000);
        fill_chunk(50, 63);

        // directed: corners, extremes, air, a type 63 block surrounded on all sides
        send_item(1'b0, 1, 1, 1, 6'd63);
        send_item(1'b0, 0, 1, 1, 6'd1);
        send_item(1'b0, 2, 1, 1, 6'd1);
        send_item(1'b0, 1, 0, 1, 6'd1);
        send_item(1'b0, 1, 2, 1, 6'd1);
        send_item(1'b0, 1, 1, 0, 6'd1);
        send_item(1'b0, 1, 1, 2, 6'd1);
        send_item(1'b1, 1, 1, 1, 6'd0);
        send_item(1'b0, 0, 0, 0, 6'd42);
        send_item(1'b1, 0, 0, 0, 6'd0);
        send_item(1'b0, 15, 15, 15, 6'd63);
        send_item(1'b1, 15, 15, 15, 6'd63);
        send_item(1'b1, 0, 15, 15, 6'd21);
        send_item(1'b1, 15, 0, 0, 6'd0);
        send_item(1'b0, 14, 14, 14, 6'd0);
        send_item(1'b1, 14, 14, 14, 6'd0);
        send_item(1'b0, 1, 1, 2, 6'd0);
        send_item(1'b1, 1, 1, 1, 6'd0);
        go_idle();

        // long receiver hold-off while the sender keeps going
        hold_off = 400;
        mesh_random(40);
        go_idle();

        write_reg(CFG_OPAQUE_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_AIR_TYPE, 6'd63);
        write_reg(CFG_CHUNK_POS_X, 64'h8000);
        write_reg(CFG_CHUNK_POS_Z, 64'h7FFF);
        mesh_random(60);
        go_idle();

        write_reg(CFG_OPAQUE_MASK, 64'h0);
        write_reg(CFG_AIR_TYPE, 6'd5);
        write_reg(CFG_CHUNK_POS_X, 64'hFFFF);
        write_reg(CFG_CHUNK_POS_Z, 64'h0);
        mesh_random(60);
        go_idle();

        write_reg(CFG_OPAQUE_MASK, {$urandom, $urandom});
        write_reg(CFG_AIR_TYPE, 6'd0);
        write_reg(CFG_CHUNK_POS_X, 64'($urandom_range(0, 65535)));
        write_reg(CFG_CHUNK_POS_Z, 64'($urandom_range(0, 65535)));
        mesh_random(90);
        go_idle();

        stim_done = 1;
        $display("covered %0d mesh transactions and %0d face records over four register settings",
            mesh_sent, faces.checked);
        if (faces.errors == 0 && faces.pending.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_top failed");
        $finish;
    end
endmodule
